>>> hw/rtl/ilist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilist_pkg
// Shared types, codes and field widths for the indexed list engine.
// ----------------------------------------------------------------------------
package ilist_pkg;

    localparam int KIND_W         = 4;
    localparam int POS_W          = 5;
    localparam int VALUE_W        = 32;
    localparam int STATUS_W       = 2;
    localparam int CNT_PORT_W     = 5;

    localparam int S_TDATA_W      = 40;   // position + value, padded to bytes
    localparam int M_TDATA_W      = 40;   // data + status + count + empty

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND    = 4'd0,
        KIND_PREPEND   = 4'd1,
        KIND_INSERT_AT = 4'd2,
        KIND_RM_FIRST  = 4'd3,
        KIND_RM_LAST   = 4'd4,
        KIND_RM_AT     = 4'd5,
        KIND_GET_AT    = 4'd6,
        KIND_GET_FIRST = 4'd7,
        KIND_GET_LAST  = 4'd8,
        KIND_SET_AT    = 4'd9,
        KIND_COUNT     = 4'd10
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_REM  = 2'd2,
        CELL_WR   = 2'd3
    } cell_op_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic             start;  // beat accepted: apply op, load read tap
        logic             step;   // move read taps one cell towards cell 0
        cell_op_t         op;
        logic             rd;     // entry at pos is returned
        logic [POS_W-1:0] pos;
    } cell_ctrl_t;

endpackage

>>> hw/rtl/indexed_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_engine_unit
// Bounded ordered list held in a row of shifting cells. Insert and remove
// shift all cells from the position upward at once; a read value walks down a tap chain to cell 0.
// ----------------------------------------------------------------------------
// Sequence: the accepting beat applies the operation and loads the read tap
//   of the entry read; the tap chain then moves that value one cell at a time
//   to cell 0, and the result is registered onto the output once it is free.
// Throughput: one request in flight; a new beat is taken only after the last result is registered.
// Reset: list empty (count zero), no result pending; entry contents are
//   undefined until written.
// ----------------------------------------------------------------------------
module indexed_list_engine_unit #(
    parameter int CAPACITY   = ilist_pkg::CAPACITY_DEF,    // 2 .. 31
    parameter int DATA_WIDTH = ilist_pkg::DATA_WIDTH_DEF   // 1 .. 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // position[4:0], value[36:5], zero pad[39:37]
    input  logic [ilist_pkg::S_TDATA_W-1:0] s_tdata,
    // kind[3:0]
    input  logic [ilist_pkg::KIND_W-1:0]    s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // data[31:0], status[33:32], count[38:34], empty_res[39]
    output logic [ilist_pkg::M_TDATA_W-1:0] m_tdata
);
    import ilist_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       shift_reg, shift_next;
    status_t                pend_status_reg, pend_status_next;
    logic [CNT_W-1:0]       pend_count_reg, pend_count_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [VALUE_W-1:0]     m_data_reg, m_data_next;
    status_t                m_status_reg, m_status_next;
    logic [CNT_PORT_W-1:0]  m_count_reg, m_count_next;

    logic                   accept;
    kind_t                  kind;
    logic [POS_W-1:0]       pos;
    logic [VALUE_W-1:0]     value;
    logic [POS_W-1:0]       cnt5;
    logic                   full, empty, elem_ok;
    status_t                dec_status;
    cell_op_t               dec_op;
    logic                   dec_rd;
    logic [POS_W-1:0]       dec_pos;
    logic                   out_free;
    cell_ctrl_t             ctrl;
    logic [DATA_WIDTH-1:0]  ins_value;

    logic [DATA_WIDTH-1:0]  elem_w [CAPACITY];
    logic [DATA_WIDTH-1:0]  tap_w  [CAPACITY];

    assign kind     = kind_t'(s_tuser);
    assign pos      = s_tdata[POS_W-1:0];
    assign value    = s_tdata[POS_W +: VALUE_W];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign cnt5    = POS_W'(count_reg);
    assign full    = (cnt5 >= CAP_POS);
    assign empty   = (count_reg == '0);
    assign elem_ok = (pos < cnt5);

    assign ins_value = DATA_WIDTH'($signed(value));

    always_comb begin
        dec_status = ST_OK;
        dec_op     = CELL_HOLD;
        dec_rd     = 1'b0;
        dec_pos    = '0;
        unique case (kind)
            KIND_APPEND: begin
                if (full) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_op  = CELL_INS;
                    dec_pos = cnt5;
                end
            end
            KIND_PREPEND: begin
                if (full) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_op = CELL_INS;
                end
            end
            KIND_INSERT_AT: begin
                if (pos > cnt5) begin
                    dec_status = ST_BAD_INDEX;
                end else if (full) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_op  = CELL_INS;
                    dec_pos = pos;
                end
            end
            KIND_RM_FIRST, KIND_GET_FIRST: begin
                if (empty) begin
                    dec_status = ST_EMPTY;
                end else begin
                    dec_op = (kind == KIND_RM_FIRST) ? CELL_REM : CELL_HOLD;
                    dec_rd = 1'b1;
                end
            end
            KIND_RM_LAST, KIND_GET_LAST: begin
                if (empty) begin
                    dec_status = ST_EMPTY;
                end else begin
                    dec_op  = (kind == KIND_RM_LAST) ? CELL_REM : CELL_HOLD;
                    dec_rd  = 1'b1;
                    dec_pos = cnt5 - 1'b1;
                end
            end
            KIND_RM_AT, KIND_GET_AT, KIND_SET_AT: begin
                if (!elem_ok) begin
                    dec_status = ST_BAD_INDEX;
                end else begin
                    dec_rd  = 1'b1;
                    dec_pos = pos;
                    if (kind == KIND_RM_AT) begin
                        dec_op = CELL_REM;
                    end else if (kind == KIND_SET_AT) begin
                        dec_op = CELL_WR;
                    end
                end
            end
            default: begin
                dec_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        ctrl.start = accept;
        ctrl.step  = (state_reg == S_RUN) && (shift_reg != '0);
        ctrl.op    = dec_op;
        ctrl.rd    = dec_rd;
        ctrl.pos   = dec_pos;
    end

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        shift_next       = shift_reg;
        pend_status_next = pend_status_reg;
        pend_count_next  = pend_count_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_data_next      = m_data_reg;
        m_status_next    = m_status_reg;
        m_count_next     = m_count_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (dec_op == CELL_INS) begin
                        count_next = count_reg + 1'b1;
                    end else if (dec_op == CELL_REM) begin
                        count_next = count_reg - 1'b1;
                    end
                    shift_next       = dec_rd ? IDX_W'(dec_pos) : '0;
                    pend_status_next = dec_status;
                    pend_count_next  = count_next;
                    state_next       = S_RUN;
                end
            end
            S_RUN: begin
                if (shift_reg != '0) begin
                    shift_next = shift_reg - 1'b1;
                end else if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = VALUE_W'($signed(tap_w[0]));
                    m_status_next = pend_status_reg;
                    m_count_next  = CNT_PORT_W'(pend_count_reg);
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        shift_reg       <= shift_next;
        pend_status_reg <= pend_status_next;
        pend_count_reg  <= pend_count_next;
        m_data_reg      <= m_data_next;
        m_status_reg    <= m_status_next;
        m_count_reg     <= m_count_next;
    end

    // cell chain; ends fed with filler data that never reaches a live entry or the result
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] lower_d, upper_d, upper_t;
        if (i == 0) begin : g_bot
            assign lower_d = ins_value;
        end else begin : g_mid_lo
            assign lower_d = elem_w[i-1];
        end
        if (i == CAPACITY - 1) begin : g_top
            assign upper_d = elem_w[i];
            assign upper_t = '0;
        end else begin : g_mid_hi
            assign upper_d = elem_w[i+1];
            assign upper_t = tap_w[i+1];
        end
        ilist_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .ins_data   (ins_value),
            .lower_data (lower_d),
            .upper_data (upper_d),
            .upper_tap  (upper_t),
            .elem       (elem_w[i]),
            .tap        (tap_w[i])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(m_count_reg == '0), m_count_reg, m_status_reg, m_data_reg};

    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list count beyond capacity");

    a_refused_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && dec_status != ST_OK) |=> $stable(count_reg))
        else $error("refused request changed the count");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_RUN) && !s_tready)
        else $error("second request taken while one is in flight");

    a_result_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RUN && state_next == S_IDLE) |=> m_tvalid_reg)
        else $error("run finished without a result beat");

endmodule

>>> hw/rtl/ilist_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilist_cell
// One list entry: shifts with its neighbours on insert and remove, and owns
// one stage of the read-out chain that carries a read value towards cell 0.
// ----------------------------------------------------------------------------
module ilist_cell #(
    parameter int DATA_WIDTH = ilist_pkg::DATA_WIDTH_DEF,
    parameter int INDEX      = 0
) (
    input  logic                   aclk,
    input  ilist_pkg::cell_ctrl_t  ctrl,
    input  logic [DATA_WIDTH-1:0]  ins_data,
    input  logic [DATA_WIDTH-1:0]  lower_data,
    input  logic [DATA_WIDTH-1:0]  upper_data,
    input  logic [DATA_WIDTH-1:0]  upper_tap,
    output logic [DATA_WIDTH-1:0]  elem,
    output logic [DATA_WIDTH-1:0]  tap
);
    import ilist_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

    logic [DATA_WIDTH-1:0] elem_reg, elem_next;
    logic [DATA_WIDTH-1:0] tap_reg, tap_next;
    logic                  hit, above;

    assign hit   = (ctrl.pos == MY_POS);
    assign above = (MY_POS > ctrl.pos);

    always_comb begin
        elem_next = elem_reg;
        if (ctrl.start) begin
            case (ctrl.op)
                CELL_INS: begin
                    if (above) begin
                        elem_next = lower_data;
                    end else if (hit) begin
                        elem_next = ins_data;
                    end
                end
                CELL_REM: begin
                    if (hit || above) begin
                        elem_next = upper_data;
                    end
                end
                CELL_WR: begin
                    if (hit) begin
                        elem_next = ins_data;
                    end
                end
                default: elem_next = elem_reg;
            endcase
        end
    end

    // tap takes the old value on the beat, so a removal or overwrite returns it
    always_comb begin
        tap_next = tap_reg;
        if (ctrl.start) begin
            tap_next = (ctrl.rd && hit) ? elem_reg : '0;
        end else if (ctrl.step) begin
            tap_next = upper_tap;
        end
    end

    always_ff @(posedge aclk) begin
        elem_reg <= elem_next;
        tap_reg  <= tap_next;
    end

    assign elem = elem_reg;
    assign tap  = tap_reg;

endmodule
